/* hw/rtl/tds_pkg.sv */
// Package for the tridiagonal solver: shared types and Q16.16 constants.
// No dependencies.
`default_nettype none
package tds_pkg;
  localparam int QW = 32;
  localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;
  localparam int DIV_STEPS = 48;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_U,
    ST_WAIT_U,
    ST_DIV_G,
    ST_WAIT_G,
    ST_BACK_RD,
    ST_BACK_MUL,
    ST_BACK_WR,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_row;
    logic mul_a;
    logic mul_b;
    logic div_u_start;
    logic div_g_start;
    logic store_u;
    logic store_g;
    logic back_rd;
    logic back_mul;
    logic back_wr;
    logic emit_init;
    logic emit_rd;
    logic emit_load;
    logic sys_clear;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic is_last;
    logic back_done;
    logic emit_done;
  } stat_t;

  // Saturate a 64-bit signed value to 32 bits
  function automatic logic signed [QW-1:0] sat32(input logic signed [63:0] v);
    logic signed [QW-1:0] r;
    if (v > 64'(Q_MAX)) r = Q_MAX;
    else if (v < 64'(Q_MIN)) r = Q_MIN;
    else r = v[QW-1:0];
    return r;
  endfunction

  // Product of two Q16.16 values, floor shift then saturate
  function automatic logic signed [QW-1:0] qmul_fin(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    return sat32(s);
  endfunction

  function automatic logic signed [QW-1:0] qsub(input logic signed [QW-1:0] x,
                                                input logic signed [QW-1:0] y);
    logic signed [63:0] d;
    d = 64'(x) - 64'(y);
    return sat32(d);
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/tridiagonal_system_solver.sv */
// Top level of the tridiagonal solver: controller plus datapath.
// Uses tds_pkg, tds_ctrl, tds_datapath.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | sub_diag main_diag super_diag rhs last_row
//  out     | out_valid/out_stall| solution row_index singular last_result
//
// Each row but the last runs the shared 48-step serial divider twice (u, then
// gamma), the last row once; the input stalls until the controller is idle.
// After the last row: back substitution (read, multiply, write a row), then emission.
// Synchronous reset clears control only; the stores need no clearing.
// A stall on the output holds the result register and pauses emission.
`default_nettype none
module tridiagonal_system_solver #(
  parameter int MAX_ROWS = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic signed [31:0] sub_diag,
  input  wire logic signed [31:0] main_diag,
  input  wire logic signed [31:0] super_diag,
  input  wire logic signed [31:0] rhs,
  input  wire logic last_row,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic signed [31:0] solution,
  output logic [5:0] row_index,
  output logic singular,
  output logic last_result
);
  tds_pkg::cmd_t cmd;
  tds_pkg::stat_t st;

  tds_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .st(st), .cmd(cmd)
  );

  tds_datapath #(.MAX_ROWS(MAX_ROWS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .sub_diag(sub_diag), .main_diag(main_diag), .super_diag(super_diag),
    .rhs(rhs), .last_row(last_row),
    .solution(solution), .row_index(row_index), .singular(singular),
    .last_result(last_result)
  );
endmodule
`default_nettype wire

/* hw/rtl/tds_div.sv */
// Restoring divider: sat32((n*65536)/d), truncated toward zero, one bit a cycle.
// Uses tds_pkg.
`default_nettype none
module tds_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic             done,
  output logic signed [31:0] quo
);
  logic [47:0] dvd;
  logic [47:0] q;
  logic [48:0] rem;
  logic [31:0] dmag;
  logic        neg, dz, nz, npos;
  logic [5:0]  cnt;
  logic        busy;
  logic [48:0] trial;
  logic [48:0] shifted;
  logic signed [63:0] sq;

  // Shift-subtract step
  always_comb begin
    shifted = {rem[47:0], dvd[47]};
    trial = shifted - {17'd0, dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(tds_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
      dmag <= den[31] ? 32'(-den) : 32'(den);
      neg  <= num[31] ^ den[31];
      dz   <= (den == 32'sd0);
      nz   <= (num == 32'sd0);
      npos <= ~num[31];
      rem  <= '0;
      q    <= '0;
    end else if (busy) begin
      dvd <= {dvd[46:0], 1'b0};
      if (!trial[48]) begin
        rem <= trial;
        q   <= {q[46:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[46:0], 1'b0};
      end
    end
  end

  // Sign and saturation of the quotient
  always_comb begin
    sq = neg ? -$signed({16'd0, q}) : $signed({16'd0, q});
    if (dz) quo = nz ? 32'sd0 : (npos ? tds_pkg::Q_MAX : tds_pkg::Q_MIN);
    else quo = tds_pkg::sat32(sq);
  end
endmodule
`default_nettype wire

/* hw/rtl/tds_ctrl.sv */
// Controller state machine for the solver. Uses tds_pkg types.
// Drives commands to tds_datapath, reads its status.
`default_nettype none
module tds_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic out_stall,
  output logic      out_valid,
  input  wire tds_pkg::stat_t st,
  output tds_pkg::cmd_t cmd
);
  tds_pkg::state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tds_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tds_pkg::ST_IDLE:     if (in_valid) state_next = tds_pkg::ST_MUL_A;
      tds_pkg::ST_MUL_A:    state_next = tds_pkg::ST_MUL_B;
      tds_pkg::ST_MUL_B:    state_next = tds_pkg::ST_DIV_U;
      tds_pkg::ST_DIV_U:    state_next = tds_pkg::ST_WAIT_U;
      tds_pkg::ST_WAIT_U:
        if (st.div_done) state_next = st.is_last ? tds_pkg::ST_BACK_RD : tds_pkg::ST_DIV_G;
      tds_pkg::ST_DIV_G:    state_next = tds_pkg::ST_WAIT_G;
      tds_pkg::ST_WAIT_G:   if (st.div_done) state_next = tds_pkg::ST_IDLE;
      tds_pkg::ST_BACK_RD:
        state_next = st.back_done ? tds_pkg::ST_EMIT_RD : tds_pkg::ST_BACK_MUL;
      tds_pkg::ST_BACK_MUL: state_next = tds_pkg::ST_BACK_WR;
      tds_pkg::ST_BACK_WR:  state_next = tds_pkg::ST_BACK_RD;
      tds_pkg::ST_EMIT_RD:  if (!out_valid || !out_stall) state_next = tds_pkg::ST_EMIT;
      tds_pkg::ST_EMIT:     state_next = st.emit_done ? tds_pkg::ST_IDLE : tds_pkg::ST_EMIT_RD;
      default:              state_next = tds_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_stall = (state != tds_pkg::ST_IDLE);
    out_valid_next = out_valid && out_stall;
    unique case (state)
      tds_pkg::ST_IDLE:     cmd.load_row = in_valid;
      tds_pkg::ST_MUL_A:    cmd.mul_a = 1'b1;
      tds_pkg::ST_MUL_B:    cmd.mul_b = 1'b1;
      tds_pkg::ST_DIV_U:    cmd.div_u_start = 1'b1;
      tds_pkg::ST_WAIT_U:   cmd.store_u = st.div_done;
      tds_pkg::ST_DIV_G:    cmd.div_g_start = 1'b1;
      tds_pkg::ST_WAIT_G:   cmd.store_g = st.div_done;
      tds_pkg::ST_BACK_RD: begin
        cmd.back_rd = ~st.back_done;
        cmd.emit_init = st.back_done;
      end
      tds_pkg::ST_BACK_MUL: cmd.back_mul = 1'b1;
      tds_pkg::ST_BACK_WR:  cmd.back_wr = 1'b1;
      tds_pkg::ST_EMIT_RD:  cmd.emit_rd = 1'b1;
      tds_pkg::ST_EMIT: begin
        cmd.emit_load = 1'b1;
        cmd.sys_clear = st.emit_done;
        out_valid_next = 1'b1;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* hw/rtl/tds_datapath.sv */
// Datapath for the solver: row registers, stores, multiplier, divider, output register.
// Uses tds_pkg and tds_div.
`default_nettype none
module tds_datapath #(
  parameter int MAX_ROWS = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire tds_pkg::cmd_t cmd,
  output tds_pkg::stat_t st,
  input  wire logic signed [31:0] sub_diag,
  input  wire logic signed [31:0] main_diag,
  input  wire logic signed [31:0] super_diag,
  input  wire logic signed [31:0] rhs,
  input  wire logic last_row,
  output logic signed [31:0] solution,
  output logic [5:0] row_index,
  output logic singular,
  output logic last_result
);
  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic signed [31:0] gamma_mem [MAX_ROWS];
  logic signed [31:0] part_mem  [MAX_ROWS];

  logic signed [31:0] a_r, b_r, c_r, r_r, bet, gam_rd, prt_rd, prt_hi;
  logic signed [63:0] prod;
  logic [AW-1:0] row, idx;
  logic          last_r, zero_seen;
  logic          div_start, div_done;
  logic signed [31:0] div_num, div_den, div_q;
  logic signed [31:0] mul_x, mul_y;

  assign st.div_done  = div_done;
  assign st.is_last   = last_r;
  assign st.back_done = (idx == '0);
  assign st.emit_done = (idx == '0);

  // One shared multiplier, registered
  always_comb begin
    mul_x = a_r;
    mul_y = gam_rd;
    if (cmd.mul_b) mul_y = prt_rd;
    if (cmd.back_mul) begin
      mul_x = gam_rd;
      mul_y = prt_hi;
    end
  end

  assign div_start = cmd.div_u_start | cmd.div_g_start;
  assign div_num = cmd.div_g_start ? c_r : ((row == '0) ? r_r : tds_pkg::qsub(r_r, tds_pkg::qmul_fin(prod)));
  assign div_den = bet;

  tds_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  // Control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      zero_seen <= 1'b0;
    end else begin
      if (cmd.mul_b && (((row == '0) ? b_r : tds_pkg::qsub(b_r, tds_pkg::qmul_fin(prod))) == 32'sd0))
        zero_seen <= 1'b1;
      if (cmd.store_g) row <= row + AW'(1);
      if (cmd.sys_clear) begin
        row <= '0;
        zero_seen <= 1'b0;
      end
    end
  end

  // Row capture, arithmetic and stores
  always_ff @(posedge clk) begin
    if (cmd.load_row) begin
      a_r <= sub_diag;
      b_r <= main_diag;
      c_r <= super_diag;
      r_r <= rhs;
      last_r <= last_row | (row == AW'(MAX_ROWS - 1));
      gam_rd <= gamma_mem[row];
      prt_rd <= part_mem[(row == '0) ? row : row - AW'(1)];
    end
    if (cmd.mul_a) prod <= 64'(mul_x) * 64'(mul_y);
    if (cmd.mul_b) begin
      bet  <= (row == '0) ? b_r : tds_pkg::qsub(b_r, tds_pkg::qmul_fin(prod));
      prod <= 64'(mul_x) * 64'(mul_y);
    end
    if (cmd.store_u) begin
      part_mem[row] <= div_q;
      prt_hi <= div_q;
      idx <= row;
    end
    if (cmd.store_g && (row != AW'(MAX_ROWS - 1))) gamma_mem[row + AW'(1)] <= div_q;
    if (cmd.back_rd) begin
      gam_rd <= gamma_mem[idx];
      prt_rd <= part_mem[idx - AW'(1)];
    end
    if (cmd.back_mul) prod <= 64'(mul_x) * 64'(mul_y);
    if (cmd.back_wr) begin
      prt_hi <= tds_pkg::qsub(prt_rd, tds_pkg::qmul_fin(prod));
      part_mem[idx - AW'(1)] <= tds_pkg::qsub(prt_rd, tds_pkg::qmul_fin(prod));
      idx <= idx - AW'(1);
    end
    // Emission starts again from the last row of the system
    if (cmd.emit_init) idx <= row;
    if (cmd.emit_rd && !cmd.back_rd) prt_rd <= part_mem[idx];
    if (cmd.emit_load) begin
      solution    <= prt_rd;
      row_index   <= 6'(idx);
      singular    <= zero_seen;
      last_result <= (idx == '0);
      if (idx != '0) idx <= idx - AW'(1);
    end
  end
endmodule
`default_nettype wire
